// File: sv/sbdl_pkg.sv
// Shared types, constants and helpers for the shell band density lookup.
// Used by every module of the block; depends on nothing else.
package sbdl_pkg;

	localparam int MAX_SHELLS = 32;
	localparam int IDX_W = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;
	localparam int CNT_W = $clog2(MAX_SHELLS + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int MAG_W = 48;
	localparam int HALF_W = MAG_W / 2;
	localparam int PROD_W = 2 * HALF_W;
	localparam int MUL_STEPS = 9;
	localparam int ROOT_STEPS = 32;
	localparam logic [63:0] ROOT_BIT0 = 64'd1 << 62;

	typedef enum logic {
		REQ_SHELL = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_CROSS,
		SH_HIGH
	} shift_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [63:0] inner;
		logic signed [63:0] outer;
		logic signed [31:0] dens;
	} shell_t;

	typedef struct packed {
		req_kind_t kind;
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic [MAG_W-1:0] mag_z;
		shell_t shell;
	} item_t;

	// Integer part of the magnitude of a signed Q48.16 value.
	function automatic logic [MAG_W-1:0] int_mag(input logic [63:0] v);
		logic [63:0] m;
		m = v[63] ? (64'd0 - v) : v;
		return m[63:16];
	endfunction

	// Places a partial product at its weight in the 64-bit sum of squares.
	function automatic logic [63:0] place_prod(input logic [PROD_W-1:0] p,
			input shift_code_t sh);
		logic [63:0] w;
		w = 64'(p);
		case (sh)
			SH_NONE: return w;
			SH_CROSS: return w << (HALF_W + 1);
			SH_HIGH: return w << (2 * HALF_W);
			default: return 64'd0;
		endcase
	endfunction

endpackage

// File: sv/sbdl_front.sv
// Front end: accepts stream transactions, classifies them and takes the
// integer magnitudes of query coordinates. Depends on sbdl_pkg.
module sbdl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [351:0]         s_tdata,
	input  logic [0:0]           s_tuser,
	output logic                 push,
	output sbdl_pkg::item_t      push_data,
	input  logic                 full
);

	logic            valid_s1;
	sbdl_pkg::item_t item_s1;
	sbdl_pkg::item_t item_in;
	logic            accept;

	assign s_tready = !valid_s1 || !full;
	assign accept = s_tvalid && s_tready;
	assign push = valid_s1;
	assign push_data = item_s1;

	always_comb begin
		item_in.kind = sbdl_pkg::req_kind_t'(s_tuser[0]);
		item_in.mag_x = sbdl_pkg::int_mag(s_tdata[63:0]);
		item_in.mag_y = sbdl_pkg::int_mag(s_tdata[127:64]);
		item_in.mag_z = sbdl_pkg::int_mag(s_tdata[191:128]);
		item_in.shell.inner = s_tdata[255:192];
		item_in.shell.outer = s_tdata[319:256];
		item_in.shell.dens = s_tdata[351:320];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: sv/sbdl_queue.sv
// Short queue between the front end and the back end.
// Depends on sbdl_pkg for the item type and depth.
module sbdl_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sbdl_pkg::item_t      push_data,
	output logic                 full,
	input  logic                 pop,
	output sbdl_pkg::item_t      pop_data,
	output logic                 empty
);

	sbdl_pkg::item_t                  slot_q [sbdl_pkg::QUEUE_DEPTH];
	logic [sbdl_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [sbdl_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [sbdl_pkg::QCNT_W-1:0]      cnt_q;
	logic                             do_push;
	logic                             do_pop;

	assign full = (cnt_q == sbdl_pkg::QCNT_W'(sbdl_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	function automatic logic [sbdl_pkg::QPTR_W-1:0] next_ptr(
			input logic [sbdl_pkg::QPTR_W-1:0] p);
		if (p == sbdl_pkg::QPTR_W'(sbdl_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/sbdl_back.sv
// Back end: shell table, sum of squares on a shared 24x24 multiplier,
// bit-pair square root, table scan and the result register. Depends on sbdl_pkg.
module sbdl_back (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 pop,
	input  sbdl_pkg::item_t      pop_data,
	input  logic                 empty,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata
);

	sbdl_pkg::state_t state_q;
	sbdl_pkg::state_t state_d;

	sbdl_pkg::shell_t                 mem [sbdl_pkg::MAX_SHELLS];
	logic [sbdl_pkg::CNT_W-1:0]       cnt_q;

	logic [sbdl_pkg::MAG_W-1:0]       mx_q;
	logic [sbdl_pkg::MAG_W-1:0]       my_q;
	logic [sbdl_pkg::MAG_W-1:0]       mz_q;
	logic [3:0]                       step_q;
	logic [sbdl_pkg::PROD_W-1:0]      prod_s1;
	sbdl_pkg::shift_code_t            sh_s1;
	logic [63:0]                      acc_q;
	logic [63:0]                      res_q;
	logic [63:0]                      bit_q;
	logic [4:0]                       iter_q;
	logic [sbdl_pkg::CNT_W-1:0]       idx_q;
	logic                             rdv_s1;
	sbdl_pkg::shell_t                 rd_s1;
	logic [31:0]                      dens_q;
	logic                             m_tvalid_q;
	logic [31:0]                      m_tdata_q;

	logic [sbdl_pkg::MAG_W-1:0]       mag_sel;
	logic [sbdl_pkg::HALF_W-1:0]      op_a;
	logic [sbdl_pkg::HALF_W-1:0]      op_b;
	sbdl_pkg::shift_code_t            sh_sel;
	logic [63:0]                      trial;
	logic signed [63:0]               radius;
	logic                             hit;
	logic                             rd_en;
	logic                             scan_end;
	logic                             mul_last;
	logic                             root_last;
	logic                             out_free;
	logic                             wr_en;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign trial = res_q + bit_q;
	assign radius = {res_q[47:0], 16'h0000};
	assign hit = rdv_s1 && (rd_s1.inner <= radius) && (radius <= rd_s1.outer);
	assign rd_en = (idx_q < cnt_q) && !hit;
	assign scan_end = !rdv_s1 && (idx_q >= cnt_q);
	assign mul_last = (step_q == 4'(sbdl_pkg::MUL_STEPS));
	assign root_last = (iter_q == 5'(sbdl_pkg::ROOT_STEPS - 1));
	assign wr_en = pop && (pop_data.kind == sbdl_pkg::REQ_SHELL)
		&& (cnt_q < sbdl_pkg::CNT_W'(sbdl_pkg::MAX_SHELLS));

	always_comb begin
		case (step_q)
			4'd0, 4'd1, 4'd2: mag_sel = mx_q;
			4'd3, 4'd4, 4'd5: mag_sel = my_q;
			default: mag_sel = mz_q;
		endcase
		case (step_q)
			4'd0, 4'd3, 4'd6: begin
				op_a = mag_sel[sbdl_pkg::HALF_W-1:0];
				op_b = mag_sel[sbdl_pkg::HALF_W-1:0];
				sh_sel = sbdl_pkg::SH_NONE;
			end
			4'd1, 4'd4, 4'd7: begin
				op_a = mag_sel[sbdl_pkg::MAG_W-1:sbdl_pkg::HALF_W];
				op_b = mag_sel[sbdl_pkg::HALF_W-1:0];
				sh_sel = sbdl_pkg::SH_CROSS;
			end
			4'd2, 4'd5, 4'd8: begin
				op_a = mag_sel[sbdl_pkg::MAG_W-1:sbdl_pkg::HALF_W];
				op_b = mag_sel[sbdl_pkg::MAG_W-1:sbdl_pkg::HALF_W];
				sh_sel = sbdl_pkg::SH_HIGH;
			end
			default: begin
				op_a = '0;
				op_b = '0;
				sh_sel = sbdl_pkg::SH_NONE;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		case (state_q)
			sbdl_pkg::ST_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (pop_data.kind == sbdl_pkg::REQ_QUERY) begin
						state_d = sbdl_pkg::ST_MUL;
					end
				end
			end
			sbdl_pkg::ST_MUL: begin
				if (mul_last) begin
					state_d = sbdl_pkg::ST_ROOT;
				end
			end
			sbdl_pkg::ST_ROOT: begin
				if (root_last) begin
					state_d = sbdl_pkg::ST_SCAN;
				end
			end
			sbdl_pkg::ST_SCAN: begin
				if (hit || scan_end) begin
					state_d = sbdl_pkg::ST_DONE;
				end
			end
			sbdl_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sbdl_pkg::ST_IDLE;
				end
			end
			default: state_d = sbdl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbdl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rdv_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == sbdl_pkg::ST_SCAN) begin
				rdv_s1 <= rd_en;
			end else begin
				rdv_s1 <= 1'b0;
			end
			if (state_q == sbdl_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[sbdl_pkg::IDX_W-1:0]] <= pop_data.shell;
		end
		if (state_q == sbdl_pkg::ST_SCAN && rd_en) begin
			rd_s1 <= mem[idx_q[sbdl_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sbdl_pkg::ST_IDLE: begin
				mx_q <= pop_data.mag_x;
				my_q <= pop_data.mag_y;
				mz_q <= pop_data.mag_z;
				step_q <= '0;
				acc_q <= '0;
			end
			sbdl_pkg::ST_MUL: begin
				if (step_q != '0) begin
					acc_q <= acc_q + sbdl_pkg::place_prod(prod_s1, sh_s1);
				end
				prod_s1 <= op_a * op_b;
				sh_s1 <= sh_sel;
				step_q <= step_q + 1'b1;
				res_q <= '0;
				bit_q <= sbdl_pkg::ROOT_BIT0;
				iter_q <= '0;
			end
			sbdl_pkg::ST_ROOT: begin
				if (acc_q >= trial) begin
					acc_q <= acc_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				iter_q <= iter_q + 1'b1;
				idx_q <= '0;
			end
			sbdl_pkg::ST_SCAN: begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (hit) begin
					dens_q <= rd_s1.dens;
				end else if (scan_end) begin
					dens_q <= '0;
				end
			end
			sbdl_pkg::ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= dens_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/shell_band_density_lookup.sv
// Top level of the shell band density lookup: front end, queue and back end.
// Depends on sbdl_pkg, sbdl_front, sbdl_queue and sbdl_back.
//
//   Channel   Direction  Signals                          Contents
//   s_*       in         s_tvalid s_tready s_tdata s_tuser shell or query transaction
//   m_*       out        m_tvalid m_tready m_tdata         density of one query
//
// A shell transaction passes the front register and the queue and is written into the table,
// if it has room, when the back end pops it while idle. A query passes the same path, then
// takes the sum of squares on the shared multiplier, the bit-pair square root, a scan of the
// stored shells that stops at the first hit, and the result register before m_tvalid. Reset
// clears the shell count, the queue and all valid flags, not the table. The input accepts
// while the queue has room, even when a result waits.
module shell_band_density_lookup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, shell_inner, shell_outer, shell_density
	input  logic [351:0] s_tdata,
	// req_type
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// density
	output logic [31:0]  m_tdata
);

	logic            push;
	sbdl_pkg::item_t push_data;
	logic            full;
	logic            pop;
	sbdl_pkg::item_t pop_data;
	logic            empty;

	sbdl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sbdl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	sbdl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: dv/tb_shell_band_density_lookup.sv
`timescale 1ns / 1ps
// Self-checking testbench for shell_band_density_lookup: shell transactions feed a local
// predictor of the shell table, and query results are checked against its radius lookup.
// Depends on sbdl_pkg and the shell_band_density_lookup RTL.
module tb_shell_band_density_lookup;

	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 1200;
	localparam logic [63:0] POS_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] POS_BOTTOM = 64'h8000_0000_0000_0001;

	typedef struct {
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
	} point_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [351:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;

	logic signed [63:0] band_lo [sbdl_pkg::MAX_SHELLS];
	logic signed [63:0] band_hi [sbdl_pkg::MAX_SHELLS];
	logic [31:0] band_dens [sbdl_pkg::MAX_SHELLS];
	int band_total;
	logic [31:0] density_q [$];
	point_t hot_points [16];
	logic [31:0] want_density;
	int mismatch_count;
	int quiet_cycles;
	bit steady_flow;
	logic out_hold = 1'b0;
	event out_hold_start;

	shell_band_density_lookup uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] whole_mag(input logic [63:0] v);
		logic [63:0] m;
		m = v[63] ? (64'd0 - v) : v;
		return m >> 16;
	endfunction

	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] acc;
		logic [63:0] probe;
		acc = 64'd0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 64'd0) begin
			if (v >= acc + probe) begin
				v = v - (acc + probe);
				acc = (acc >> 1) + probe;
			end else begin
				acc = acc >> 1;
			end
			probe = probe >> 2;
		end
		return acc;
	endfunction

	function automatic logic signed [63:0] point_radius(input point_t p);
		logic [63:0] total_sq;
		total_sq = whole_mag(p.x) * whole_mag(p.x) + whole_mag(p.y) * whole_mag(p.y)
			+ whole_mag(p.z) * whole_mag(p.z);
		return floor_root(total_sq) << 16;
	endfunction

	function automatic logic [31:0] band_lookup(input logic signed [63:0] r);
		for (int i = 0; i < band_total; i++) begin
			if (band_lo[i] <= r && r <= band_hi[i])
				return band_dens[i];
		end
		return 32'd0;
	endfunction

	function automatic logic [351:0] pack_fields(input point_t p, input logic [63:0] lo,
			input logic [63:0] hi, input logic [31:0] dens);
		return {dens, hi, lo, p.z, p.y, p.x};
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] q_whole(input longint n);
		return 64'(n) << 16;
	endfunction

	function automatic logic [63:0] mk_coord(input longint n);
		logic [63:0] m;
		m = (64'(n < 0 ? -n : n) << 16) | 64'($urandom_range(0, 65535));
		return (n < 0) ? -m : m;
	endfunction

	function automatic logic [63:0] rand_coord();
		logic [63:0] m;
		int bits;
		case ($urandom_range(0, 9))
			0: begin
				m = rand64();
				return (m == 64'h8000_0000_0000_0000) ? 64'd0 : m;
			end
			1: begin
				case ($urandom_range(0, 2))
					0: return POS_TOP;
					1: return POS_BOTTOM;
					default: return 64'd0;
				endcase
			end
			2: bits = $urandom_range(0, 47);
			default: bits = $urandom_range(0, 31);
		endcase
		m = rand64() & ((64'd1 << (bits + 16)) - 64'd1);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.x = rand_coord();
		p.y = rand_coord();
		p.z = rand_coord();
		return p;
	endfunction

	function automatic logic [63:0] rand_offset();
		case ($urandom_range(0, 4))
			0: return 64'd0;
			1: return 64'd1;
			2: return 64'd1 << 16;
			3: return 64'($urandom_range(0, 255)) << 16;
			default: return rand64() >> $urandom_range(1, 63);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t: %s: expected %h, got %h", $time, what, want, got);
		mismatch_count++;
	endtask

	task automatic send_item(input sbdl_pkg::req_kind_t kind, input logic [351:0] data);
		point_t p;
		while (!steady_flow && $urandom_range(0, 99) < 18) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		if (kind == sbdl_pkg::REQ_SHELL) begin
			if (band_total < sbdl_pkg::MAX_SHELLS) begin
				band_lo[band_total] = data[255:192];
				band_hi[band_total] = data[319:256];
				band_dens[band_total] = data[351:320];
				band_total++;
			end
		end else begin
			p.x = data[63:0];
			p.y = data[127:64];
			p.z = data[191:128];
			density_q.push_back(band_lookup(point_radius(p)));
		end
	endtask

	task automatic send_shell(input logic [63:0] lo, input logic [63:0] hi,
			input logic [31:0] dens);
		send_item(sbdl_pkg::REQ_SHELL, pack_fields(rand_point(), lo, hi, dens));
	endtask

	task automatic send_query(input point_t p);
		send_item(sbdl_pkg::REQ_QUERY, pack_fields(p, rand64(), rand64(), $urandom));
	endtask

	task automatic send_query_at(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] z);
		point_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		send_query(p);
	endtask

	task automatic rand_shell(output logic [63:0] lo, output logic [63:0] hi,
			output logic [31:0] dens);
		logic signed [63:0] r;
		case ($urandom_range(0, 9))
			0: begin
				r = point_radius(rand_point());
				lo = r + 64'd1 + rand_offset();
				hi = r;
			end
			1: begin
				lo = rand64();
				hi = rand64();
			end
			2, 3, 4, 5: begin
				r = point_radius(hot_points[$urandom_range(0, 15)]);
				lo = r - rand_offset();
				hi = r + rand_offset();
			end
			default: begin
				r = point_radius(rand_point());
				lo = r - rand_offset();
				hi = r + rand_offset();
			end
		endcase
		case ($urandom_range(0, 7))
			0: dens = 32'h8000_0000;
			1: dens = 32'h7FFF_FFFF;
			2: dens = 32'd0;
			default: dens = $urandom;
		endcase
	endtask

	task automatic test_empty_table;
		send_query_at(64'd0, 64'd0, 64'd0);
		send_query_at(POS_TOP, POS_TOP, POS_TOP);
		send_query_at(POS_BOTTOM, POS_BOTTOM, POS_TOP);
	endtask

	// Overlapping, inverted and never-reachable bands; queries land on band edges.
	task automatic test_band_matching;
		send_shell(q_whole(0), q_whole(5), 32'h0001_8000);
		send_query_at(mk_coord(3), mk_coord(-4), mk_coord(0));
		send_shell(q_whole(100), q_whole(50), 32'h7FFF_FFFF);
		send_shell(q_whole(3), q_whole(10), 32'h8000_0000);
		send_shell(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
		send_shell(q_whole(20) + 64'd1, q_whole(30) - 64'd1, 32'h0002_0000);
		send_shell(POS_TOP, POS_TOP, 32'hFFFF_FFFF);
		send_query_at(mk_coord(-6), mk_coord(8), mk_coord(0));
		send_query_at(mk_coord(0), mk_coord(0), mk_coord(7));
		send_query_at(mk_coord(1), mk_coord(-1), mk_coord(1));
		send_query_at(mk_coord(20), mk_coord(0), mk_coord(0));
		send_query_at(mk_coord(0), mk_coord(25), mk_coord(0));
		send_query_at(mk_coord(-30), mk_coord(0), mk_coord(0));
		send_query_at(mk_coord(5), mk_coord(5), mk_coord(-5));
		send_query_at(64'h0001_0000_0000_0000, mk_coord(0), mk_coord(0));
		send_query_at(POS_BOTTOM, POS_TOP, POS_BOTTOM);
	endtask

	task automatic test_output_stall;
		-> out_hold_start;
		repeat (12) send_query(rand_point());
	endtask

	task automatic test_random_traffic(input int count);
		point_t p;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [31:0] dens;
		for (int i = 0; i < 16; i++)
			hot_points[i] = rand_point();
		for (int i = 0; i < count; i++) begin
			steady_flow = (i >= 400 && i < 600);
			if ($urandom_range(0, 9) == 0) begin
				rand_shell(lo, hi, dens);
				send_shell(lo, hi, dens);
			end else if ($urandom_range(0, 9) < 4) begin
				p = hot_points[$urandom_range(0, 15)];
				if ($urandom_range(0, 1))
					p.x = -p.x;
				if ($urandom_range(0, 1))
					p.y = -p.y;
				if ($urandom_range(0, 1))
					p.z = -p.z;
				send_query(p);
			end else begin
				send_query(rand_point());
			end
		end
		steady_flow = 1'b0;
	endtask

	always @(posedge clk) begin
		if (out_hold)
			m_tready <= 1'b0;
		else
			m_tready <= steady_flow || ($urandom_range(0, 99) >= 18);
	end

	always begin
		@(out_hold_start);
		out_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		out_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (density_q.size() == 0) begin
				report_mismatch("density with no query pending", 32'd0, m_tdata);
			end else begin
				want_density = density_q.pop_front();
				if (m_tdata !== want_density)
					report_mismatch("density", want_density, m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("** shell_band_density_lookup: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		arst_n <= 1'b0;
		steady_flow = 1'b0;
		band_total = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_band_matching();
		test_output_stall();
		test_random_traffic(RANDOM_ITEMS);
		s_tvalid <= 1'b0;
		while (density_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** shell_band_density_lookup: PASSED **");
		else
			$display("** shell_band_density_lookup: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
sv/sbdl_pkg.sv
sv/sbdl_front.sv
sv/sbdl_queue.sv
sv/sbdl_back.sv
sv/shell_band_density_lookup.sv
dv/tb_shell_band_density_lookup.sv
